[hdl/lbos_pkg.sv]
// ---------------------------------------------------------------------------
// LED boost output sequencer package
// Shared types and constants for the sequencer and its channel interfaces.
// ---------------------------------------------------------------------------
package lbos_pkg;

  typedef enum logic [3:0] {
    ST_STANDBY    = 4'd0,
    ST_PRECHARGE  = 4'd1,
    ST_AUX        = 4'd2,
    ST_BOOST      = 4'd3,
    ST_RELEASE    = 4'd4,
    ST_SUBMIT     = 4'd5,
    ST_ENABLED    = 4'd6,
    ST_ONELM      = 4'd7,
    ST_SHUT       = 4'd8,
    ST_DECAY      = 4'd9,
    ST_ENTER_IDLE = 4'd10,
    ST_IDLE       = 4'd11,
    ST_FAILED     = 4'd12
  } state_e;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_ONELM    = 3'd1,
    MODE_MAX      = 3'd2,
    MODE_FLASH    = 3'd3,
    MODE_DISTRESS = 3'd4,
    MODE_ERROR    = 3'd5
  } mode_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] CFG_PRECHARGE_START = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ONE_LUMEN_DAC   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STROBE_HALT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TURBO_STEP      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_CLAMP     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SLOW_THRESH     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ONE_LUMEN_SEED  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_DISCHARGE_VOLT  = 3'd7;

  localparam int unsigned PIN_DAC   = 0;
  localparam int unsigned PIN_AUX   = 1;
  localparam int unsigned PIN_BOOST = 2;
  localparam int unsigned PIN_LED   = 3;

  localparam logic [9:0] BoostUpVolt    = 10'd178;
  localparam logic [9:0] IdleVoltNormal = 10'd215;
  localparam logic [9:0] IdleVoltStrobe = 10'd235;
  localparam logic [5:0] BoostTimeout   = 6'd20;
  localparam logic [5:0] DecayTimeout   = 6'd36;
  localparam logic [15:0] StrobeStep    = 16'd2000;
  localparam logic [15:0] SosStep       = 16'd800;
  localparam logic [15:0] NormalStep    = 16'd15;
  localparam logic [11:0] MaxReleaseStep = 12'd200;
  localparam logic [2:0] HeartbeatDiv   = 3'd4;

  typedef struct packed {
    logic             req_type;
    logic signed [15:0] target_current;
    logic [14:0]      thermal_limit;
    logic [2:0]       mode_class;
    logic [9:0]       output_volt;
    logic             upload_pending;
    logic             special_mode;
    logic             input_limited;
    logic             mppt_grant;
    logic             high_power_strobe;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       state_code;
    logic signed [15:0] drive_setpoint;
    logic [11:0]      precharge_value;
    logic             request_upload;
    logic [3:0]       pin_enables;
    logic             heartbeat_led;
    logic             vout_sample_only;
    logic             output_started;
    logic             ramp_done;
    logic             start_fault;
    logic             output_enabled;
    logic             power_off_busy;
  } out_word_t;

endpackage

[hdl/lbos_in_if.sv]
// ---------------------------------------------------------------------------
// LED boost sequencer input channel
// Valid/ready channel that carries one input word.
// ---------------------------------------------------------------------------
interface lbos_in_if;
  import lbos_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/lbos_out_if.sv]
// ---------------------------------------------------------------------------
// LED boost sequencer output channel
// Valid/ready channel that carries one result word.
// ---------------------------------------------------------------------------
interface lbos_out_if;
  import lbos_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/led_boost_output_sequencer.sv]
// ---------------------------------------------------------------------------
// LED boost output sequencer
// Start-up, run and shutdown state machine for a boost LED driver.
// ---------------------------------------------------------------------------
// Each accepted word is processed combinationally by the next-state logic and the
// result word is held in an output register, so one word per cycle is sustained while
// the sink keeps taking results; the single output register sets that figure.
module led_boost_output_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbos_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lbos_pkg::CfgDataW-1:0] cfg_data_i,
  lbos_in_if.sink                       in_if,
  lbos_out_if.source                    out_if
);
  import lbos_pkg::*;

  logic [11:0] pre_start_q, one_lm_dac_q, strobe_halt_q;
  logic [9:0]  turbo_step_q, seed_q, dis_volt_q;
  logic [14:0] start_clamp_q, slow_thr_q;

  state_e state_q, state_d;
  logic [5:0] timer_q, timer_d;
  logic [2:0] hb_cnt_q, hb_cnt_d;
  logic hb_lvl_q, hb_lvl_d;
  logic signed [15:0] applied_q, applied_d, drive_q, drive_d;
  logic [11:0] pre_q, pre_d;
  logic slow_q, slow_d, rise_q, rise_d, started_q, started_d;
  logic rdone_q, rdone_d, vonly_q, vonly_d;
  logic [3:0] pin_q, pin_d;
  logic upl, fault;

  logic out_valid_q;
  out_word_t out_q;
  logic accept;
  in_word_t iw;

  logic signed [16:0] tc;
  logic signed [16:0] diff, ramp_sum;
  logic signed [16:0] rel_st;
  logic [11:0] start_dac, rel_step, one_lm_plus;
  logic [12:0] one_lm_sum;

  assign iw = in_if.data;
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_start_q   <= 12'd2294;
      one_lm_dac_q  <= 12'd2214;
      strobe_halt_q <= 12'd1894;
      turbo_step_q  <= 10'd180;
      start_clamp_q <= 15'd1000;
      slow_thr_q    <= 15'd3333;
      seed_q        <= 10'd30;
      dis_volt_q    <= 10'd196;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRECHARGE_START: pre_start_q   <= cfg_data_i[11:0];
        CFG_ONE_LUMEN_DAC:   one_lm_dac_q  <= cfg_data_i[11:0];
        CFG_STROBE_HALT:     strobe_halt_q <= cfg_data_i[11:0];
        CFG_TURBO_STEP:      turbo_step_q  <= cfg_data_i[9:0];
        CFG_START_CLAMP:     start_clamp_q <= cfg_data_i[14:0];
        CFG_SLOW_THRESH:     slow_thr_q    <= cfg_data_i[14:0];
        CFG_ONE_LUMEN_SEED:  seed_q        <= cfg_data_i[9:0];
        CFG_DISCHARGE_VOLT:  dis_volt_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign start_dac = (one_lm_dac_q > pre_start_q) ? one_lm_dac_q : pre_start_q;
  assign one_lm_sum = {1'b0, one_lm_dac_q} + 13'd20;
  assign one_lm_plus = one_lm_sum[12] ? 12'hFFF : one_lm_sum[11:0];

  always_comb begin
    tc = 17'(iw.target_current);
    if (iw.target_current > 16'sd0 && $signed({2'b00, iw.thermal_limit}) < tc) begin
      tc = $signed({2'b00, iw.thermal_limit});
    end
  end

  assign diff = tc - 17'(applied_q);
  assign rel_st = 17'sd1 + (tc >>> 3) + ((tc < 0 && tc[2:0] != 3'd0) ? 17'sd1 : 17'sd0);
  assign rel_step = (rel_st < 0) ? 12'd0 :
                    (rel_st > 17'sd200) ? MaxReleaseStep : rel_st[11:0];

  always_comb begin
    state_d = state_q; timer_d = timer_q; hb_cnt_d = hb_cnt_q; hb_lvl_d = hb_lvl_q;
    applied_d = applied_q; drive_d = drive_q; pre_d = pre_q; slow_d = slow_q;
    rise_d = rise_q; started_d = started_q; rdone_d = rdone_q; vonly_d = vonly_q;
    pin_d = pin_q; upl = 1'b0; fault = 1'b0; ramp_sum = '0;
    if (iw.req_type) begin
      if (iw.mode_class == MODE_ONELM) begin
        hb_lvl_d = 1'b0;
      end else if (state_q == ST_SUBMIT || state_q == ST_ENABLED || state_q == ST_ONELM) begin
        hb_lvl_d = 1'b1;
      end else if (iw.mode_class != MODE_ERROR && hb_cnt_q < HeartbeatDiv) begin
        hb_cnt_d = hb_cnt_q + 3'd1;
      end else begin
        hb_lvl_d = !hb_lvl_q;
        hb_cnt_d = '0;
      end
      if (timer_q != '0) timer_d = timer_q - 6'd1;
    end else begin
      if (iw.mppt_grant) rise_d = 1'b1;
      if (tc == 0 && (state_q == ST_ONELM || state_q == ST_RELEASE || state_q == ST_SUBMIT ||
                      state_q == ST_ENABLED || state_q == ST_IDLE)) begin
        state_d = ST_SHUT;
        vonly_d = 1'b1;
      end
      case (state_d)
        ST_FAILED: begin
          pin_d = '0;
          hb_lvl_d = 1'b0; hb_cnt_d = '0;
          applied_d = '0; rdone_d = 1'b0; slow_d = 1'b0;
          state_d = ST_STANDBY;
        end
        ST_STANDBY: begin
          pin_d = '0;
          rdone_d = 1'b0; started_d = 1'b0; vonly_d = 1'b0; rise_d = 1'b0;
          if (pre_q != '0 || drive_q > 0) begin
            pre_d = '0; drive_d = '0; upl = 1'b1;
          end
          if (tc > 0) state_d = ST_PRECHARGE;
        end
        ST_PRECHARGE: begin
          pin_d[PIN_DAC] = 1'b1;
          if (iw.mode_class == MODE_ONELM) applied_d = 16'($unsigned(seed_q));
          else if (tc > $signed({2'b00, start_clamp_q})) applied_d = 16'(start_clamp_q);
          else applied_d = tc[15:0];
          drive_d = applied_d;
          pre_d = start_dac;
          upl = 1'b1;
          state_d = ST_AUX;
        end
        ST_AUX: begin
          if (!iw.upload_pending) begin
            pin_d[PIN_AUX] = 1'b1;
            timer_d = BoostTimeout;
            state_d = ST_BOOST;
          end
        end
        ST_BOOST: begin
          pin_d[PIN_BOOST] = 1'b1;
          if (timer_q == '0) begin
            fault = 1'b1; state_d = ST_FAILED;
          end
          if (iw.output_volt >= BoostUpVolt) begin
            state_d = (iw.mode_class == MODE_ONELM) ? ST_ONELM : ST_RELEASE;
          end
        end
        ST_RELEASE: begin
          pin_d[PIN_LED] = 1'b1;
          if (!iw.upload_pending) begin
            if (pre_q == '0) state_d = ST_ENABLED;
            else if (pre_q < rel_step) pre_d = '0;
            else pre_d = pre_q - rel_step;
            upl = 1'b1;
          end
        end
        ST_SUBMIT: begin
          if (!iw.upload_pending) begin
            if (diff > $signed({2'b00, slow_thr_q})) slow_d = 1'b1;
            if (!iw.special_mode && slow_d) begin
              ramp_sum = 17'(applied_q);
              case (iw.mode_class)
                MODE_MAX: begin
                  if (rise_d && !iw.input_limited) begin
                    ramp_sum = 17'(applied_q) + 17'($unsigned(turbo_step_q));
                    rise_d = 1'b0;
                  end
                end
                MODE_FLASH:    ramp_sum = 17'(applied_q) + 17'(StrobeStep);
                MODE_DISTRESS: ramp_sum = 17'(applied_q) + 17'(SosStep);
                default:       ramp_sum = 17'(applied_q) + 17'(NormalStep);
              endcase
              if (ramp_sum >= tc) begin
                slow_d = 1'b0; applied_d = tc[15:0];
              end else begin
                applied_d = ramp_sum[15:0];
              end
            end else begin
              applied_d = tc[15:0];
            end
            upl = 1'b1;
            drive_d = applied_d;
            if (tc == 17'(applied_d)) begin
              rdone_d = 1'b1; state_d = ST_ENABLED;
            end
          end
        end
        ST_ONELM: begin
          if (tc > 2) state_d = ST_RELEASE;
          if (pre_q > one_lm_dac_q && !iw.upload_pending) begin
            pre_d = pre_q - 12'd1; upl = 1'b1;
          end
          pin_d[PIN_LED] = 1'b1;
        end
        ST_ENABLED: begin
          started_d = 1'b1;
          if (tc == 2) begin
            state_d = ST_ONELM;
            pre_d = one_lm_plus;
            drive_d = 16'($unsigned(seed_q));
          end
          if (tc == -1) state_d = ST_ENTER_IDLE;
          if (diff != 0) state_d = ST_SUBMIT;
        end
        ST_SHUT: begin
          pin_d[PIN_BOOST] = 1'b0;
          pin_d[PIN_LED] = 1'b1;
          pin_d[PIN_DAC] = 1'b0;
          if (pre_q != '0 || drive_q > 0) begin
            pre_d = '0; drive_d = '0; upl = 1'b1;
          end
          timer_d = DecayTimeout;
          state_d = ST_DECAY;
        end
        ST_DECAY: begin
          if (!(iw.output_volt > dis_volt_q && timer_q != '0)) begin
            vonly_d = 1'b0;
            pin_d = '0;
            if (pre_q != '0 || drive_q > 0) begin
              pre_d = '0; drive_d = '0; upl = 1'b1;
            end
            timer_d = '0;
            state_d = ST_STANDBY;
          end
        end
        ST_ENTER_IDLE: begin
          pre_d = iw.high_power_strobe ? strobe_halt_q : start_dac;
          upl = 1'b1;
          vonly_d = 1'b1;
          if (iw.output_volt <= (iw.high_power_strobe ? IdleVoltStrobe : IdleVoltNormal)) begin
            pin_d[PIN_LED] = 1'b0;
            state_d = ST_IDLE;
            vonly_d = 1'b0;
          end
        end
        ST_IDLE: begin
          if (tc > 0) begin
            pin_d[PIN_LED] = 1'b1;
            pre_d = '0;
            upl = 1'b1;
            state_d = ST_SUBMIT;
          end
        end
        default: state_d = ST_FAILED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STANDBY; timer_q <= '0; hb_cnt_q <= '0; hb_lvl_q <= 1'b0;
      applied_q <= '0; drive_q <= '0; pre_q <= '0; slow_q <= 1'b0; rise_q <= 1'b0;
      started_q <= 1'b0; rdone_q <= 1'b0; vonly_q <= 1'b0; pin_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d; timer_q <= timer_d; hb_cnt_q <= hb_cnt_d; hb_lvl_q <= hb_lvl_d;
        applied_q <= applied_d; drive_q <= drive_d; pre_q <= pre_d; slow_q <= slow_d;
        rise_q <= rise_d; started_q <= started_d; rdone_q <= rdone_d; vonly_q <= vonly_d;
        pin_q <= pin_d;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.state_code <= state_d;
      out_q.drive_setpoint <= drive_d;
      out_q.precharge_value <= pre_d;
      out_q.request_upload <= upl;
      out_q.pin_enables <= pin_d;
      out_q.heartbeat_led <= hb_lvl_d;
      out_q.vout_sample_only <= vonly_d;
      out_q.output_started <= started_d;
      out_q.ramp_done <= rdone_d;
      out_q.start_fault <= fault;
      out_q.output_enabled <= (state_d == ST_SUBMIT || state_d == ST_ENABLED ||
                               state_d == ST_ONELM);
      out_q.power_off_busy <= (state_d == ST_SHUT || state_d == ST_DECAY);
    end
  end

  a_fault_to_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fault |-> state_d == ST_FAILED || state_d == ST_ONELM || state_d == ST_RELEASE)
    else $error("start fault without leaving boost state");
  a_tick_no_upload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && iw.req_type |=> !out_q.request_upload && !out_q.start_fault)
    else $error("tick word reported upload or fault");
  a_out_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");
endmodule
